// ----- rtl/rfpe_pkg.sv -----
// Shared types, opcodes and constants for the rectangle fill pixel engine.
package rfpe_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int OP_W      = 3;
    localparam int COORD_W   = 8;
    localparam int DIM_W     = 9;
    localparam int PIX_W     = 8;
    localparam int CFG_IDX_W = 1;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_CLEAR       = 3'd0;
    localparam op_t OP_FILL_COPY   = 3'd1;
    localparam op_t OP_FILL_INVERT = 3'd2;
    localparam op_t OP_PUT_PIXEL   = 3'd3;
    localparam op_t OP_GET_PIXEL   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILL,
        ST_INV_RD,
        ST_INV_WR,
        ST_GET_RD,
        ST_GET_WAIT,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mem_we;
        logic invert;
        logic advance;
        logic capture;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_t  op;
        logic reject;
        logic last;
    } dp_stat_t;

endpackage

// ----- rtl/rfpe_ram.sv -----
// Generic single-port RAM with registered read data.
module rfpe_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 65536,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write on we, read every cycle (old data on a same-cycle write)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/rfpe_ctrl.sv -----
// Command sequencer for the pixel engine: walks fills, inverts and reads.
module rfpe_ctrl
    import rfpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.reject)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    case (stat.op)
                        OP_CLEAR:       state_next = ST_FILL;
                        OP_FILL_COPY:   state_next = ST_FILL;
                        OP_PUT_PIXEL:   state_next = ST_FILL;
                        OP_FILL_INVERT: state_next = ST_INV_RD;
                        OP_GET_PIXEL:   state_next = ST_GET_RD;
                        default:        state_next = ST_DONE;
                    endcase
                end
            end
            ST_FILL:
            begin
                cmd.mem_we = 1'b1;
                if (stat.last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            ST_INV_RD:
            begin
                state_next = ST_INV_WR;
            end
            ST_INV_WR:
            begin
                cmd.mem_we = 1'b1;
                cmd.invert = 1'b1;
                if (stat.last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_INV_RD;
                end
            end
            ST_GET_RD:
            begin
                state_next = ST_GET_WAIT;
            end
            ST_GET_WAIT:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/rfpe_dp.sv -----
// Datapath: size registers, command checks, rectangle walker and result.
module rfpe_dp
    import rfpe_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  op_t                  op,
    input  logic [COORD_W-1:0]   x_left,
    input  logic [COORD_W-1:0]   y_top,
    input  logic [COORD_W-1:0]   x_right,
    input  logic [COORD_W-1:0]   y_bottom,
    input  logic [PIX_W-1:0]     color,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 mem_we,
    output logic [ADDR_W-1:0]    mem_addr,
    output logic [PIX_W-1:0]     mem_wdata,
    input  logic [PIX_W-1:0]     mem_rdata,
    output logic [PIX_W-1:0]     read_pixel,
    output logic                 status
);

    localparam int PROD_W = COORD_W + DIM_W;

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;

    op_t                op_reg;
    logic               reject_reg;
    logic [PIX_W-1:0]   color_reg;
    logic [DIM_W-1:0]   x_lo_reg;
    logic [DIM_W-1:0]   x_hi_reg;
    logic [DIM_W-1:0]   y_hi_reg;
    logic [DIM_W-1:0]   x_reg;
    logic [DIM_W-1:0]   y_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [PIX_W-1:0]   pix_reg;

    logic               reject_next;
    logic [DIM_W-1:0]   x_lo_next;
    logic [DIM_W-1:0]   x_hi_next;
    logic [DIM_W-1:0]   y_lo_next;
    logic [DIM_W-1:0]   y_hi_next;
    logic [ADDR_W-1:0]  base_next;
    logic [PROD_W-1:0]  row_prod;
    logic               fill_bad;
    logic               pix_bad;
    logic               x_end;

    // Hold the size registers, reset to full area
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // Clamp sizes: zero acts as one, above the store bound acts as the bound
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // Check coordinates against the area
    assign fill_bad = (x_left > x_right) || (y_top > y_bottom) ||
                      (DIM_W'(x_right) >= w_eff) || (DIM_W'(y_bottom) >= h_eff);
    assign pix_bad  = (DIM_W'(x_left) >= w_eff) || (DIM_W'(y_top) >= h_eff);

    // Start address of the first row
    assign row_prod = PROD_W'(y_top) * PROD_W'(w_eff);

    // Decode walk bounds for the new command
    always_comb
    begin
        x_lo_next   = DIM_W'(x_left);
        x_hi_next   = DIM_W'(x_right);
        y_lo_next   = DIM_W'(y_top);
        y_hi_next   = DIM_W'(y_bottom);
        base_next   = ADDR_W'(row_prod);
        reject_next = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                x_lo_next = '0;
                x_hi_next = w_eff - DIM_W'(1);
                y_lo_next = '0;
                y_hi_next = h_eff - DIM_W'(1);
                base_next = '0;
            end
            OP_FILL_COPY,
            OP_FILL_INVERT:
            begin
                reject_next = fill_bad;
            end
            OP_PUT_PIXEL,
            OP_GET_PIXEL:
            begin
                x_hi_next   = DIM_W'(x_left);
                y_hi_next   = DIM_W'(y_top);
                reject_next = pix_bad;
            end
            default:
            begin
                reject_next = 1'b0;
            end
        endcase
    end

    assign x_end = (x_reg == x_hi_reg);

    // Load a command, step the walker, capture read data
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            reject_reg <= reject_next;
            color_reg  <= color;
            x_lo_reg   <= x_lo_next;
            x_hi_reg   <= x_hi_next;
            y_hi_reg   <= y_hi_next;
            x_reg      <= x_lo_next;
            y_reg      <= y_lo_next;
            base_reg   <= base_next;
            pix_reg    <= '0;
        end
        else
        begin
            if (cmd.advance)
            begin
                if (x_end)
                begin
                    x_reg    <= x_lo_reg;
                    y_reg    <= y_reg + DIM_W'(1);
                    base_reg <= base_reg + ADDR_W'(w_eff);
                end
                else
                begin
                    x_reg <= x_reg + DIM_W'(1);
                end
            end
            if (cmd.capture)
            begin
                pix_reg <= mem_rdata;
            end
        end
    end

    // Drive memory and status
    assign mem_we     = cmd.mem_we;
    assign mem_addr   = base_reg + ADDR_W'(x_reg);
    assign mem_wdata  = cmd.invert ? ~mem_rdata : color_reg;

    assign stat.op     = op_reg;
    assign stat.reject = reject_reg;
    assign stat.last   = x_end && (y_reg == y_hi_reg);

    assign read_pixel = pix_reg;
    assign status     = reject_reg;

endmodule

// ----- rtl/rect_fill_pixel_engine_core.sv -----
// Top level of the rectangle fill pixel engine: sequencer, datapath, frame store.
// A command runs decode, then fill states (clear, fill_copy, put_pixel), read and write
// states in turn (fill_invert) or read and wait states (get_pixel), then done; a
// rejected or unused op goes from decode to done. One command at a time, taken in the
// idle cycle after done; the single frame store port gives a write per pixel, or a read
// and a write per inverted pixel. Results strobe one cycle on done and cannot be held off.
// Reset returns the sequencer to idle and both sizes to 256; the frame store is not cleared.
module rect_fill_pixel_engine_core
    import rfpe_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      op,
    input  logic [COORD_W-1:0]   x_left,
    input  logic [COORD_W-1:0]   y_top,
    input  logic [COORD_W-1:0]   x_right,
    input  logic [COORD_W-1:0]   y_bottom,
    input  logic [PIX_W-1:0]     color,
    output logic                 done,
    output logic [PIX_W-1:0]     read_pixel,
    output logic                 status
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [PIX_W-1:0]   mem_wdata;
    logic [PIX_W-1:0]   mem_rdata;

    // Size registers take a beat on any cycle
    assign cfg_ready = 1'b1;

    rfpe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    rfpe_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .x_left     (x_left),
        .y_top      (y_top),
        .x_right    (x_right),
        .y_bottom   (y_bottom),
        .color      (color),
        .cmd        (cmd),
        .stat       (stat),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata),
        .read_pixel (read_pixel),
        .status     (status)
    );

    rfpe_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // An accepted command keeps the engine busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepting a command");

    // The result beat ends the command
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("engine still busy after result beat");

    // A result only comes from a busy engine
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while idle");

    // A rejected command reads no pixel
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (read_pixel == '0))
        else $error("rejected command returned pixel data");

    // No frame store write outside a command
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (busy && !done))
        else $error("frame store write outside a command");

endmodule
